// File: rtl/qlv_pkg.sv
`timescale 1ns / 1ps
// Shared codes for the quorum lock voter: message kinds in and reply kinds out.
// No dependencies; imported by the voter top level.
package qlv_pkg;

	typedef logic [1:0] op_t;
	typedef logic [1:0] kind_t;

	// incoming message kinds
	localparam op_t OP_REQUEST    = 2'd0;
	localparam op_t OP_RELEASE    = 2'd1;
	localparam op_t OP_RELINQUISH = 2'd2;
	localparam op_t OP_UNUSED     = 2'd3;

	// reply kinds
	localparam kind_t KIND_GRANT   = 2'd0;
	localparam kind_t KIND_FAILED  = 2'd1;
	localparam kind_t KIND_INQUIRE = 2'd2;

endpackage

// File: rtl/qlv_cell.sv
`timescale 1ns / 1ps
// One wait slot of the voter queue plus one registered step of the search chain.
// Standalone; chained QUEUE_DEPTH times by quorum_lock_voter.
module qlv_cell #(
	parameter int QUEUE_DEPTH = 32,
	parameter int ID_BITS     = 6,
	parameter int CELL_IDX    = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] set_idx,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] clr_idx,
	input  logic                           set_en,
	input  logic                           clr_en,
	input  logic [ID_BITS-1:0]             set_val,
	input  logic [2*$clog2(QUEUE_DEPTH)+ID_BITS+1:0] carry_in,
	output logic [2*$clog2(QUEUE_DEPTH)+ID_BITS+1:0] carry_out
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	typedef struct packed {
		logic               has_min;
		logic [ID_BITS-1:0] min_id;
		logic [IDX_W-1:0]   min_idx;
		logic               has_empty;
		logic [IDX_W-1:0]   empty_idx;
	} carry_t;

	logic [ID_BITS-1:0] slot_q;
	carry_t cin;
	carry_t cnext;
	carry_t cout_q;

	assign cin = carry_t'(carry_in);
	assign carry_out = cout_q;

	// hold the slot; a set wins over a clear at the same index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (set_en && set_idx == MY_IDX) begin
			slot_q <= set_val;
		end else if (clr_en && clr_idx == MY_IDX) begin
			slot_q <= '0;
		end
	end

	// fold this slot into the running minimum and first-empty search
	always_comb begin
		cnext = cin;
		if (slot_q != '0 && (!cin.has_min || slot_q < cin.min_id)) begin
			cnext.has_min = 1'b1;
			cnext.min_id  = slot_q;
			cnext.min_idx = MY_IDX;
		end
		if (slot_q == '0 && !cin.has_empty) begin
			cnext.has_empty = 1'b1;
			cnext.empty_idx = MY_IDX;
		end
	end

	// advance the search one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout_q <= '0;
		end else begin
			cout_q <= cnext;
		end
	end

endmodule

// File: rtl/quorum_lock_voter.sv
`timescale 1ns / 1ps
// Flow: a message is taken in ST_IDLE, the search wave walks the chain of wait-slot
// cells one cell per cycle in ST_SCAN, and ST_DECIDE loads the reply buffer that
// drives out_valid once that buffer is empty. No new message is taken until the
// decision is made; ignored messages skip the search.
// Replies (up to two) sit in a two-entry output buffer, so the next message is
// taken while they drain. Async reset empties every slot and frees the lock.
module quorum_lock_voter #(
	parameter int QUEUE_DEPTH = 32,
	parameter int ID_BITS     = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qlv_pkg::op_t        op,
	input  logic [ID_BITS-1:0]  node_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ID_BITS-1:0]  dest_id,
	output qlv_pkg::kind_t      kind,
	output logic                last,
	output logic                queue_full
);

	import qlv_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CW    = 2 * IDX_W + ID_BITS + 2;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	typedef struct packed {
		logic               has_min;
		logic [ID_BITS-1:0] min_id;
		logic [IDX_W-1:0]   min_idx;
		logic               has_empty;
		logic [IDX_W-1:0]   empty_idx;
	} carry_t;

	typedef struct packed {
		logic               set_en;
		logic               clr_en;
		logic [IDX_W-1:0]   set_idx;
		logic [IDX_W-1:0]   clr_idx;
		logic [ID_BITS-1:0] set_val;
	} slot_wr_t;

	typedef struct packed {
		logic [ID_BITS-1:0] dest;
		kind_t              kind;
		logic               last;
		logic               full;
	} reply_t;

	logic [1:0]         state_q;
	logic [IDX_W-1:0]   cnt_q;
	op_t                op_q;
	logic [ID_BITS-1:0] sender_q;
	logic               held_q;
	logic [ID_BITS-1:0] holder_q;
	logic               inq_q;
	logic [1:0]         ob_cnt_q;
	reply_t             ob0_q;
	reply_t             ob1_q;

	logic [CW-1:0] carry [QUEUE_DEPTH+1];
	carry_t        scan;
	slot_wr_t      wr;
	slot_wr_t      cell_wr;
	reply_t        r0;
	reply_t        r1;
	logic [1:0]    rep_n;
	logic          held_d;
	logic [ID_BITS-1:0] holder_d;
	logic          inq_d;
	logic          fire;
	logic          in_xfer;
	logic          out_xfer;

	// chain of wait-slot cells
	assign carry[0] = '0;
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		qlv_cell #(
			.QUEUE_DEPTH(QUEUE_DEPTH),
			.ID_BITS    (ID_BITS),
			.CELL_IDX   (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.set_idx  (cell_wr.set_idx),
			.clr_idx  (cell_wr.clr_idx),
			.set_en   (cell_wr.set_en),
			.clr_en   (cell_wr.clr_en),
			.set_val  (cell_wr.set_val),
			.carry_in (carry[i]),
			.carry_out(carry[i+1])
		);
	end
	assign scan = carry_t'(carry[QUEUE_DEPTH]);

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_valid = (ob_cnt_q != 2'd0);
	assign out_xfer  = out_valid && out_ready;
	assign fire      = (state_q == ST_DECIDE) && (ob_cnt_q == 2'd0);
	assign cell_wr   = fire ? wr : '0;

	assign dest_id    = ob0_q.dest;
	assign kind       = ob0_q.kind;
	assign last       = ob0_q.last;
	assign queue_full = ob0_q.full;

	// decide replies and queue updates from the finished search
	always_comb begin
		rep_n    = 2'd0;
		r0       = '0;
		r1       = '0;
		wr       = '0;
		held_d   = held_q;
		holder_d = holder_q;
		inq_d    = inq_q;
		unique case (op_q)
			OP_REQUEST: begin
				if (!held_q) begin
					r0       = '{dest: sender_q, kind: KIND_GRANT, last: 1'b0, full: 1'b0};
					rep_n    = 2'd1;
					held_d   = 1'b1;
					holder_d = sender_q;
				end else if (!scan.has_empty) begin
					r0    = '{dest: sender_q, kind: KIND_FAILED, last: 1'b0, full: 1'b1};
					rep_n = 2'd1;
				end else begin
					wr.set_en  = 1'b1;
					wr.set_idx = scan.empty_idx;
					wr.set_val = sender_q;
					if ((scan.has_min && scan.min_id < sender_q) || sender_q > holder_q) begin
						r0    = '{dest: sender_q, kind: KIND_FAILED, last: 1'b0, full: 1'b0};
						rep_n = 2'd1;
					end else if ((!scan.has_min || scan.min_id > sender_q)
							&& sender_q < holder_q) begin
						if (scan.has_min && scan.min_id < holder_q) begin
							r0    = '{dest: scan.min_id, kind: KIND_FAILED, last: 1'b0,
								full: 1'b0};
							rep_n = 2'd1;
						end
						if (!inq_q) begin
							inq_d = 1'b1;
							if (rep_n == 2'd0) begin
								r0 = '{dest: holder_q, kind: KIND_INQUIRE, last: 1'b0,
									full: 1'b0};
							end else begin
								r1 = '{dest: holder_q, kind: KIND_INQUIRE, last: 1'b0,
									full: 1'b0};
							end
							rep_n = rep_n + 2'd1;
						end
					end
				end
			end
			OP_RELEASE: begin
				held_d = 1'b0;
				inq_d  = 1'b0;
				if (scan.has_min) begin
					wr.clr_en  = 1'b1;
					wr.clr_idx = scan.min_idx;
					r0         = '{dest: scan.min_id, kind: KIND_GRANT, last: 1'b0, full: 1'b0};
					rep_n      = 2'd1;
					held_d     = 1'b1;
					holder_d   = scan.min_id;
				end
			end
			OP_RELINQUISH: begin
				inq_d  = 1'b0;
				held_d = 1'b1;
				rep_n  = 2'd1;
				if (!scan.has_min) begin
					r0       = '{dest: sender_q, kind: KIND_GRANT, last: 1'b0, full: 1'b0};
					holder_d = sender_q;
				end else begin
					r0         = '{dest: scan.min_id, kind: KIND_GRANT, last: 1'b0, full: 1'b0};
					holder_d   = scan.min_id;
					wr.set_en  = 1'b1;
					wr.set_val = sender_q;
					// the freed slot is reused when it is the first empty one
					if (!scan.has_empty || scan.min_idx < scan.empty_idx) begin
						wr.set_idx = scan.min_idx;
					end else begin
						wr.set_idx = scan.empty_idx;
						wr.clr_en  = 1'b1;
						wr.clr_idx = scan.min_idx;
					end
				end
			end
			default: begin
				rep_n = 2'd0;
			end
		endcase
		if (rep_n == 2'd1) begin
			r0.last = 1'b1;
		end
		if (rep_n == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	// sequence: take a message, let the search wave cross the chain, decide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			op_q     <= OP_REQUEST;
			sender_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && node_id != '0 && op != OP_UNUSED) begin
						op_q     <= op;
						sender_q <= node_id;
						cnt_q    <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == IDX_W'(QUEUE_DEPTH - 1)) begin
						state_q <= ST_DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// lock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			holder_q <= '0;
			inq_q    <= 1'b0;
		end else if (fire) begin
			held_q   <= held_d;
			holder_q <= holder_d;
			inq_q    <= inq_d;
		end
	end

	// two-entry reply buffer: load when empty, drop the head on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= 2'd0;
		end else if (fire) begin
			ob_cnt_q <= rep_n;
		end else if (out_xfer) begin
			ob_cnt_q <= ob_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ob0_q <= r0;
			ob1_q <= r1;
		end else if (out_xfer) begin
			ob0_q <= ob1_q;
		end
	end

	// a free lock has no outstanding inquiry
	assert property (@(posedge clk) disable iff (!arst_n) !held_q |-> !inq_q)
		else $error("inquiry flagged while lock is free");

	// a held lock always names a real holder
	assert property (@(posedge clk) disable iff (!arst_n) held_q |-> holder_q != '0)
		else $error("lock held with no holder");

	// a decision with replies shows them in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rep_n != 2'd0) |=> out_valid)
		else $error("replies lost after decision");

	// the lone buffered reply is the final one of its message
	assert property (@(posedge clk) disable iff (!arst_n) (ob_cnt_q == 2'd1) |-> ob0_q.last)
		else $error("single buffered reply not marked last");

	// a full-queue flag rides only on a failed reply
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && queue_full) |-> (kind == KIND_FAILED))
		else $error("queue_full on a reply that is not failed");

endmodule
